FILE: design/ssvi_pkg.sv
// Shared types and constants for the SSVI implied-volatility pipeline.
// No dependencies; imported by the lookup, variance and top-level modules.
`timescale 1ns / 1ps

package ssvi_pkg;

    localparam int TENORS_DEF = 16;

    localparam logic signed [31:0] RHO_MAX = 32'sd1072668082;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_EVAL  = 1'b1;

    localparam logic REG_TENORS_IN_USE = 1'b0;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_RANGE = 2'd1;
    localparam logic [1:0] STATUS_SAT   = 2'd2;

    typedef struct packed {
        logic        valid;
        logic        err;
        logic [31:0] th;
        logic [31:0] rho;
        logic [31:0] psi;
        logic [31:0] k;
        logic [31:0] t;
    } ssvi_lookup_t;

    typedef struct packed {
        logic        valid;
        logic        err;
        logic        sat;
        logic [31:0] w;
        logic [31:0] t;
    } ssvi_var_t;

endpackage

FILE: design/ssvi_sqrt_pipe.sv
// Pipelined integer square root, one result bit per register stage.
// Generic; carries a sideband payload alongside the radicand.
`timescale 1ns / 1ps

module ssvi_sqrt_pipe #(
    parameter int RW = 32,
    parameter int PW = 1
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            en,
    input  logic            in_valid,
    input  logic [2*RW-1:0] in_rad,
    input  logic [PW-1:0]   in_pay,
    output logic            out_valid,
    output logic [RW-1:0]   out_root,
    output logic [PW-1:0]   out_pay
);

    logic            vld_reg  [RW];
    logic [RW+1:0]   rem_reg  [RW];
    logic [RW-1:0]   root_reg [RW];
    logic [2*RW-1:0] rad_reg  [RW];
    logic [PW-1:0]   pay_reg  [RW];

    genvar g;
    for (g = 0; g < RW; g++) begin : g_stage
        logic            p_vld;
        logic [RW+1:0]   p_rem;
        logic [RW-1:0]   p_root;
        logic [2*RW-1:0] p_rad;
        logic [PW-1:0]   p_pay;
        logic [RW+1:0]   rem_x;
        logic [RW+1:0]   trial;
        logic            ge;

        if (g == 0) begin : g_first
            assign p_vld  = in_valid;
            assign p_rem  = '0;
            assign p_root = '0;
            assign p_rad  = in_rad;
            assign p_pay  = in_pay;
        end else begin : g_next
            assign p_vld  = vld_reg[g-1];
            assign p_rem  = rem_reg[g-1];
            assign p_root = root_reg[g-1];
            assign p_rad  = rad_reg[g-1];
            assign p_pay  = pay_reg[g-1];
        end

        assign rem_x = {p_rem[RW-1:0], p_rad[2*RW-1 -: 2]};
        assign trial = {p_root, 2'b01};
        assign ge    = (rem_x >= trial);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[g] <= 1'b0;
            end else if (en) begin
                vld_reg[g] <= p_vld;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[g]  <= ge ? (rem_x - trial) : rem_x;
                root_reg[g] <= {p_root[RW-2:0], ge};
                rad_reg[g]  <= {p_rad[2*RW-3:0], 2'b00};
                pay_reg[g]  <= p_pay;
            end
        end
    end

    assign out_valid = vld_reg[RW-1];
    assign out_root  = root_reg[RW-1];
    assign out_pay   = pay_reg[RW-1];

endmodule

FILE: design/ssvi_div_pipe.sv
// Pipelined restoring divider, one quotient bit per register stage.
// Generic; carries the divisor and a sideband payload through each stage.
`timescale 1ns / 1ps

module ssvi_div_pipe #(
    parameter int NW = 64,
    parameter int DW = 32,
    parameter int PW = 1
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic          in_valid,
    input  logic [NW-1:0] in_num,
    input  logic [DW-1:0] in_den,
    input  logic [PW-1:0] in_pay,
    output logic          out_valid,
    output logic [NW-1:0] out_quo,
    output logic [PW-1:0] out_pay
);

    logic          vld_reg [NW];
    logic [DW-1:0] rem_reg [NW];
    logic [NW-1:0] quo_reg [NW];
    logic [NW-1:0] num_reg [NW];
    logic [DW-1:0] den_reg [NW];
    logic [PW-1:0] pay_reg [NW];

    genvar g;
    for (g = 0; g < NW; g++) begin : g_stage
        logic          p_vld;
        logic [DW-1:0] p_rem;
        logic [NW-1:0] p_quo;
        logic [NW-1:0] p_num;
        logic [DW-1:0] p_den;
        logic [PW-1:0] p_pay;
        logic [DW:0]   rem_x;
        logic [DW:0]   rem_s;
        logic          ge;

        if (g == 0) begin : g_first
            assign p_vld = in_valid;
            assign p_rem = '0;
            assign p_quo = '0;
            assign p_num = in_num;
            assign p_den = in_den;
            assign p_pay = in_pay;
        end else begin : g_next
            assign p_vld = vld_reg[g-1];
            assign p_rem = rem_reg[g-1];
            assign p_quo = quo_reg[g-1];
            assign p_num = num_reg[g-1];
            assign p_den = den_reg[g-1];
            assign p_pay = pay_reg[g-1];
        end

        assign rem_x = {p_rem, p_num[NW-1]};
        assign ge    = (rem_x >= {1'b0, p_den});
        assign rem_s = ge ? (rem_x - {1'b0, p_den}) : rem_x;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[g] <= 1'b0;
            end else if (en) begin
                vld_reg[g] <= p_vld;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[g] <= rem_s[DW-1:0];
                quo_reg[g] <= {p_quo[NW-2:0], ge};
                num_reg[g] <= {p_num[NW-2:0], 1'b0};
                den_reg[g] <= p_den;
                pay_reg[g] <= p_pay;
            end
        end
    end

    assign out_valid = vld_reg[NW-1];
    assign out_quo   = quo_reg[NW-1];
    assign out_pay   = pay_reg[NW-1];

endmodule

FILE: design/ssvi_tables.sv
// Tenor parameter table: stores theta, rho and psi per tenor, reads on evaluate.
// Depends on ssvi_pkg for opcodes and the lookup struct.
`timescale 1ns / 1ps

module ssvi_tables import ssvi_pkg::*; #(
    parameter int TENORS = TENORS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         en,
    input  logic         in_valid,
    input  logic         opcode,
    input  logic [3:0]   tenor,
    input  logic [31:0]  theta_value,
    input  logic [31:0]  rho_value,
    input  logic [31:0]  psi_value,
    input  logic [31:0]  log_moneyness,
    input  logic [31:0]  maturity,
    input  logic [4:0]   tenors_in_use,
    output ssvi_lookup_t lookup
);

    localparam int IW = (TENORS > 1) ? $clog2(TENORS) : 1;

    logic [95:0] mem [TENORS];
    logic [95:0] rd_reg;
    logic        vld_reg;
    logic        err_reg;
    logic [31:0] k_reg;
    logic [31:0] t_reg;

    logic [8:0]    tenor_w;
    logic          hit;
    logic [IW-1:0] idx;

    assign tenor_w = {5'd0, tenor};
    assign hit     = (tenor_w < 9'(TENORS));
    assign idx     = tenor_w[IW-1:0];

    always_ff @(posedge aclk) begin
        if (en && in_valid && (opcode == OP_WRITE) && hit) begin
            mem[idx] <= {psi_value, rho_value, theta_value};
        end
        if (en) begin
            rd_reg <= mem[idx];
            err_reg <= !hit || ({1'b0, tenor} >= tenors_in_use);
            k_reg   <= log_moneyness;
            t_reg   <= maturity;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (en) begin
            vld_reg <= in_valid && (opcode == OP_EVAL);
        end
    end

    assign lookup.valid = vld_reg;
    assign lookup.err   = err_reg;
    assign lookup.th    = rd_reg[31:0];
    assign lookup.rho   = rd_reg[63:32];
    assign lookup.psi   = rd_reg[95:64];
    assign lookup.k     = k_reg;
    assign lookup.t     = t_reg;

endmodule

FILE: design/ssvi_variance.sv
// SSVI total variance pipeline: clamps, products, two square roots, final floor.
// Depends on ssvi_pkg and ssvi_sqrt_pipe.
`timescale 1ns / 1ps

module ssvi_variance import ssvi_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         en,
    input  ssvi_lookup_t lookup,
    output ssvi_var_t    result
);

    typedef struct packed {
        logic        err;
        logic [31:0] th;
        logic        rs;
        logic [29:0] rmag;
        logic [31:0] p;
        logic        ks;
        logic [31:0] kmag;
        logic [31:0] t;
    } pay1_t;

    typedef struct packed {
        logic        err;
        logic [31:0] th;
        logic        rkneg;
        logic [37:0] rkmag;
        logic [31:0] t;
    } pay2_t;

    typedef struct packed {
        logic        err;
        logic [31:0] th;
        logic        rs;
        logic [29:0] rmag;
        logic        ks;
        logic [31:0] kmag;
        logic [31:0] t;
        logic [33:0] tp;
        logic [31:0] tr;
        logic [63:0] th2;
        logic [60:0] q;
    } stb_t;

    typedef struct packed {
        logic        err;
        logic [31:0] th;
        logic        rs;
        logic [29:0] rmag;
        logic        ks;
        logic [31:0] t;
        logic [31:0] tr;
        logic [37:0] a;
        logic [60:0] hh;
        logic [63:0] hl;
        logic [60:0] lh;
        logic [63:0] ll;
    } stc_t;

    typedef struct packed {
        logic        err;
        logic [31:0] th;
        logic [31:0] t;
        logic [63:0] c;
        logic [37:0] bmag;
        logic        rkneg;
        logic [37:0] rkmag;
    } std_t;

    typedef struct packed {
        logic        err;
        logic [31:0] th;
        logic [31:0] t;
        logic [63:0] c;
        logic        rkneg;
        logic [37:0] rkmag;
        logic [37:0] sqhh;
        logic [37:0] sqhl;
        logic [37:0] sqll;
    } ste_t;

    // stage A: clamp theta and rho, split signs
    logic               a_vld_reg;
    pay1_t              a_reg;
    logic signed [31:0] rho_s;
    logic signed [31:0] rho_c;
    logic signed [31:0] k_s;

    assign rho_s = $signed(lookup.rho);
    assign k_s   = $signed(lookup.k);
    assign rho_c = (rho_s > RHO_MAX) ? RHO_MAX : ((rho_s < -RHO_MAX) ? -RHO_MAX : rho_s);

    always_ff @(posedge aclk) begin
        if (en) begin
            a_reg.err  <= lookup.err;
            a_reg.th   <= (lookup.th == 32'd0) ? 32'd1 : lookup.th;
            a_reg.rs   <= rho_c[31];
            a_reg.rmag <= rho_c[31] ? 30'(-rho_c) : rho_c[29:0];
            a_reg.p    <= lookup.psi;
            a_reg.ks   <= k_s[31];
            a_reg.kmag <= k_s[31] ? 32'(-k_s) : lookup.k;
            a_reg.t    <= lookup.t;
        end
    end

    // sqrt(theta) in Q.28
    logic                     s1_vld;
    logic [29:0]              s1_root;
    logic [$bits(pay1_t)-1:0] s1_pay_bits;
    pay1_t                    s1_pay;

    ssvi_sqrt_pipe #(.RW(30), .PW($bits(pay1_t))) u_sqrt_theta (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (a_vld_reg),
        .in_rad    ({a_reg.th, 28'd0}),
        .in_pay    (a_reg),
        .out_valid (s1_vld),
        .out_root  (s1_root),
        .out_pay   (s1_pay_bits)
    );

    assign s1_pay = pay1_t'(s1_pay_bits);

    // stage B: theta*phi, theta*rho, theta^2, 1-rho^2
    logic        b_vld_reg;
    stb_t        b_reg;
    logic [61:0] ps;
    logic [61:0] thr;
    logic [59:0] r2;

    assign ps  = s1_pay.p * s1_root;
    assign thr = s1_pay.th * s1_pay.rmag;
    assign r2  = s1_pay.rmag * s1_pay.rmag;

    always_ff @(posedge aclk) begin
        if (en) begin
            b_reg.err  <= s1_pay.err;
            b_reg.th   <= s1_pay.th;
            b_reg.rs   <= s1_pay.rs;
            b_reg.rmag <= s1_pay.rmag;
            b_reg.ks   <= s1_pay.ks;
            b_reg.kmag <= s1_pay.kmag;
            b_reg.t    <= s1_pay.t;
            b_reg.tp   <= ps[61:28];
            b_reg.tr   <= thr[61:30];
            b_reg.th2  <= s1_pay.th * s1_pay.th;
            b_reg.q    <= (61'd1 << 60) - {1'b0, r2};
        end
    end

    // stage C: theta*phi*k and partial products of theta^2*(1-rho^2)
    logic        c_vld_reg;
    stc_t        c_reg;
    logic [65:0] ak;

    assign ak = b_reg.tp * b_reg.kmag;

    always_ff @(posedge aclk) begin
        if (en) begin
            c_reg.err  <= b_reg.err;
            c_reg.th   <= b_reg.th;
            c_reg.rs   <= b_reg.rs;
            c_reg.rmag <= b_reg.rmag;
            c_reg.ks   <= b_reg.ks;
            c_reg.t    <= b_reg.t;
            c_reg.tr   <= b_reg.tr;
            c_reg.a    <= ak[65:28];
            c_reg.hh   <= b_reg.th2[63:32] * b_reg.q[60:32];
            c_reg.hl   <= b_reg.th2[63:32] * b_reg.q[31:0];
            c_reg.lh   <= b_reg.th2[31:0] * b_reg.q[60:32];
            c_reg.ll   <= b_reg.th2[31:0] * b_reg.q[31:0];
        end
    end

    // stage D: sum partial products, form b and rho*a
    logic               d_vld_reg;
    std_t               d_reg;
    logic [124:0]       csum;
    logic signed [39:0] a_s;
    logic signed [39:0] tr_s;
    logic signed [39:0] b_s;
    logic [67:0]        rkp;

    assign csum = (125'(c_reg.hh) << 64) + (125'(c_reg.hl) << 32)
                + (125'(c_reg.lh) << 32) + 125'(c_reg.ll);
    assign a_s  = c_reg.ks ? -$signed({2'b00, c_reg.a}) : $signed({2'b00, c_reg.a});
    assign tr_s = c_reg.rs ? -$signed({8'd0, c_reg.tr}) : $signed({8'd0, c_reg.tr});
    assign b_s  = a_s + tr_s;
    assign rkp  = c_reg.a * c_reg.rmag;

    always_ff @(posedge aclk) begin
        if (en) begin
            d_reg.err   <= c_reg.err;
            d_reg.th    <= c_reg.th;
            d_reg.t     <= c_reg.t;
            d_reg.c     <= csum[123:60];
            d_reg.bmag  <= b_s[39] ? 38'(-b_s) : b_s[37:0];
            d_reg.rkneg <= c_reg.ks ^ c_reg.rs;
            d_reg.rkmag <= rkp[67:30];
        end
    end

    // stage E: partial squares of |b|
    logic e_vld_reg;
    ste_t e_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            e_reg.err   <= d_reg.err;
            e_reg.th    <= d_reg.th;
            e_reg.t     <= d_reg.t;
            e_reg.c     <= d_reg.c;
            e_reg.rkneg <= d_reg.rkneg;
            e_reg.rkmag <= d_reg.rkmag;
            e_reg.sqhh  <= d_reg.bmag[37:19] * d_reg.bmag[37:19];
            e_reg.sqhl  <= d_reg.bmag[37:19] * d_reg.bmag[18:0];
            e_reg.sqll  <= d_reg.bmag[18:0] * d_reg.bmag[18:0];
        end
    end

    // stage F: radicand b^2 + c
    logic        f_vld_reg;
    logic [79:0] f_rad_reg;
    pay2_t       f_pay_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            f_rad_reg <= (80'(e_reg.sqhh) << 38) + (80'(e_reg.sqhl) << 20)
                       + 80'(e_reg.sqll) + 80'(e_reg.c);
            f_pay_reg.err   <= e_reg.err;
            f_pay_reg.th    <= e_reg.th;
            f_pay_reg.rkneg <= e_reg.rkneg;
            f_pay_reg.rkmag <= e_reg.rkmag;
            f_pay_reg.t     <= e_reg.t;
        end
    end

    logic                     s2_vld;
    logic [39:0]              s2_root;
    logic [$bits(pay2_t)-1:0] s2_pay_bits;
    pay2_t                    s2_pay;

    ssvi_sqrt_pipe #(.RW(40), .PW($bits(pay2_t))) u_sqrt_rad (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (f_vld_reg),
        .in_rad    (f_rad_reg),
        .in_pay    (f_pay_reg),
        .out_valid (s2_vld),
        .out_root  (s2_root),
        .out_pay   (s2_pay_bits)
    );

    assign s2_pay = pay2_t'(s2_pay_bits);

    // stage G: w = (theta + rho*a + rad) / 2, floored at zero, saturated
    ssvi_var_t          g_reg;
    logic signed [42:0] rk_s;
    logic signed [42:0] sum_s;
    logic [41:0]        w0;

    assign rk_s  = s2_pay.rkneg ? -$signed({5'd0, s2_pay.rkmag})
                                : $signed({5'd0, s2_pay.rkmag});
    assign sum_s = $signed({11'd0, s2_pay.th}) + rk_s + $signed({3'd0, s2_root});
    assign w0    = (sum_s[42] || (sum_s == 43'sd0)) ? 42'd0 : sum_s[42:1];

    always_ff @(posedge aclk) begin
        if (en) begin
            g_reg.err <= s2_pay.err;
            g_reg.sat <= |w0[41:32];
            g_reg.w   <= (|w0[41:32]) ? 32'hFFFF_FFFF : w0[31:0];
            g_reg.t   <= s2_pay.t;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg   <= 1'b0;
            b_vld_reg   <= 1'b0;
            c_vld_reg   <= 1'b0;
            d_vld_reg   <= 1'b0;
            e_vld_reg   <= 1'b0;
            f_vld_reg   <= 1'b0;
            g_reg.valid <= 1'b0;
        end else if (en) begin
            a_vld_reg   <= lookup.valid;
            b_vld_reg   <= s1_vld;
            c_vld_reg   <= b_vld_reg;
            d_vld_reg   <= c_vld_reg;
            e_vld_reg   <= d_vld_reg;
            f_vld_reg   <= e_vld_reg;
            g_reg.valid <= s2_vld;
        end
    end

    assign result = g_reg;

endmodule

FILE: design/ssvi_implied_volatility.sv
// Top level of the SSVI implied-volatility evaluator: stream ports, APB register.
// Depends on ssvi_pkg, ssvi_tables, ssvi_variance, ssvi_div_pipe, ssvi_sqrt_pipe.
`timescale 1ns / 1ps

// One request enters per clock cycle while s_tready is high; each evaluate
// request gives one result, registered at the output. The pipeline depth is
// set by the bit-per-stage units: the 30-stage sqrt(theta), the 40-stage
// radical square root, the 84-stage w/T divider and the 32-stage final square
// root, plus the table read, clamp, product, radicand, floor, flag and output registers.
// Opcode 0 requests write one tenor's theta, rho and psi and give no result;
// an evaluate may follow a write to the same tenor in the next cycle.
// The pipeline only holds while a finished result waits at the output.
module ssvi_implied_volatility import ssvi_pkg::*; #(
    parameter int TENORS = TENORS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // tenor[3:0], theta_value[35:4], rho_value[67:36], psi_value[99:68],
    // log_moneyness[131:100], maturity[163:132], zero fill [167:164]
    input  logic [167:0] s_tdata,
    // opcode[0]
    input  logic [0:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // implied_vol[31:0], total_variance[63:32]
    output logic [63:0]  m_tdata,
    // status[1:0]
    output logic [1:0]   m_tuser,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    typedef struct packed {
        logic        err;
        logic        sat;
        logic [31:0] w;
    } dpay_t;

    typedef struct packed {
        logic        err;
        logic        sat;
        logic [31:0] w;
        logic        qsat;
    } hpay_t;

    logic [4:0] tiu_reg;
    logic       cfg_wr;
    logic       en;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_TENORS_IN_USE);
    assign prdata = (paddr[2] == REG_TENORS_IN_USE) ? {27'd0, tiu_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tiu_reg <= 5'd1;
        end else if (cfg_wr) begin
            tiu_reg <= pwdata[4:0];
        end
    end

    ssvi_lookup_t lookup;
    ssvi_var_t    var_res;

    ssvi_tables #(.TENORS(TENORS)) u_tables (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .en            (en),
        .in_valid      (s_tvalid),
        .opcode        (s_tuser[0]),
        .tenor         (s_tdata[3:0]),
        .theta_value   (s_tdata[35:4]),
        .rho_value     (s_tdata[67:36]),
        .psi_value     (s_tdata[99:68]),
        .log_moneyness (s_tdata[131:100]),
        .maturity      (s_tdata[163:132]),
        .tenors_in_use (tiu_reg),
        .lookup        (lookup)
    );

    ssvi_variance u_variance (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .lookup  (lookup),
        .result  (var_res)
    );

    // w * 2^52 / max(T, 1)
    dpay_t                    d_in_pay;
    logic                     dq_vld;
    logic [83:0]              dq_quo;
    logic [$bits(dpay_t)-1:0] dq_pay_bits;
    dpay_t                    dq_pay;

    assign d_in_pay.err = var_res.err;
    assign d_in_pay.sat = var_res.sat;
    assign d_in_pay.w   = var_res.w;

    ssvi_div_pipe #(.NW(84), .DW(32), .PW($bits(dpay_t))) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (var_res.valid),
        .in_num    ({var_res.w, 52'd0}),
        .in_den    ((var_res.t == 32'd0) ? 32'd1 : var_res.t),
        .in_pay    (d_in_pay),
        .out_valid (dq_vld),
        .out_quo   (dq_quo),
        .out_pay   (dq_pay_bits)
    );

    assign dq_pay = dpay_t'(dq_pay_bits);

    // flag a quotient whose root cannot fit 32 bits
    logic        h_vld_reg;
    logic [63:0] h_rad_reg;
    hpay_t       h_pay_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            h_rad_reg      <= dq_quo[63:0];
            h_pay_reg.err  <= dq_pay.err;
            h_pay_reg.sat  <= dq_pay.sat || (|dq_quo[83:64]);
            h_pay_reg.w    <= dq_pay.w;
            h_pay_reg.qsat <= |dq_quo[83:64];
        end
    end

    logic                     iv_vld;
    logic [31:0]              iv_root;
    logic [$bits(hpay_t)-1:0] iv_pay_bits;
    hpay_t                    iv_pay;

    ssvi_sqrt_pipe #(.RW(32), .PW($bits(hpay_t))) u_sqrt_iv (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (h_vld_reg),
        .in_rad    (h_rad_reg),
        .in_pay    (h_pay_reg),
        .out_valid (iv_vld),
        .out_root  (iv_root),
        .out_pay   (iv_pay_bits)
    );

    assign iv_pay = hpay_t'(iv_pay_bits);

    // advance unless a result is stuck at the output with another behind it
    logic m_tvalid_reg;
    logic out_load;

    assign en       = m_tready || !m_tvalid_reg || !iv_vld;
    assign out_load = m_tready || !m_tvalid_reg;
    assign s_tready = en;
    assign m_tvalid = m_tvalid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            h_vld_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (en) begin
                h_vld_reg <= dq_vld;
            end
            if (out_load) begin
                m_tvalid_reg <= iv_vld;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            if (iv_pay.err) begin
                m_tdata <= 64'd0;
                m_tuser <= STATUS_RANGE;
            end else begin
                m_tdata <= {iv_pay.w, iv_pay.qsat ? 32'hFFFF_FFFF : iv_root};
                m_tuser <= iv_pay.sat ? STATUS_SAT : STATUS_OK;
            end
        end
    end

    a_stall_only_on_output: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled without a blocked result");

    a_range_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser == STATUS_RANGE)) |-> (m_tdata == 64'd0))
        else $error("out-of-range tenor result carries data");

    a_cfg_write: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_wr |=> (tiu_reg == $past(pwdata[4:0])))
        else $error("tenors_in_use not updated by write");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser == STATUS_OK || m_tuser == STATUS_RANGE
                      || m_tuser == STATUS_SAT))
        else $error("undefined status code");

endmodule
